[design/jsas_pkg.sv]
`default_nettype none

package jsas_pkg;

    // Sample width and the full-scale factor of the scaled positions.
    localparam int SAMPLE_BITS = 8;
    localparam int FULL_SCALE  = 200;

    localparam int FS_BITS     = $clog2(FULL_SCALE + 1);
    localparam int PROD_BITS   = SAMPLE_BITS + FS_BITS;
    localparam int RES_BITS    = PROD_BITS + 2;

    localparam int OFFSET_BITS = 8;
    localparam int SPAN_BITS   = 8;
    localparam int DZ_BITS     = 16;
    localparam int VALUE_BITS  = 17;

    localparam int CFG_INDEX_BITS = 4;
    localparam int CFG_DATA_BITS  = 16;

    localparam logic [FS_BITS-1:0]  FULL_SCALE_C = FS_BITS'(FULL_SCALE);
    localparam logic [RES_BITS-1:0] HALF_SCALE_C = RES_BITS'(FULL_SCALE / 2);

    localparam logic signed [RES_BITS-1:0] VAL_MAX =
        RES_BITS'((2 ** (VALUE_BITS - 1)) - 1);
    localparam logic signed [RES_BITS-1:0] VAL_MIN =
        -RES_BITS'(2 ** (VALUE_BITS - 1));

    typedef logic signed [VALUE_BITS-1:0] value_t;

    typedef enum logic [1:0] {
        CH_X     = 2'd0,
        CH_Y     = 2'd1,
        CH_LEFT  = 2'd2,
        CH_RIGHT = 2'd3
    } scan_chan_t;

    typedef enum logic [2:0] {
        DIR_NEUTRAL = 3'd0,
        DIR_LEFT    = 3'd1,
        DIR_RIGHT   = 3'd2,
        DIR_DOWN    = 3'd3,
        DIR_UP      = 3'd4
    } direction_t;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_X_OFFSET    = 4'd0,
        REG_Y_OFFSET    = 4'd1,
        REG_X_SPAN      = 4'd2,
        REG_Y_SPAN      = 4'd3,
        REG_LEFT_SPAN   = 4'd4,
        REG_RIGHT_SPAN  = 4'd5,
        REG_X_DEAD_ZONE = 4'd6,
        REG_Y_DEAD_ZONE = 4'd7
    } reg_index_t;

    typedef struct packed {
        logic [OFFSET_BITS-1:0] x_offset_level;
        logic [OFFSET_BITS-1:0] y_offset_level;
        logic [SPAN_BITS-1:0]   x_span;
        logic [SPAN_BITS-1:0]   y_span;
        logic [SPAN_BITS-1:0]   left_span;
        logic [SPAN_BITS-1:0]   right_span;
        logic [DZ_BITS-1:0]     x_dead_zone;
        logic [DZ_BITS-1:0]     y_dead_zone;
    } cfg_t;

endpackage

`default_nettype wire

[design/jsas_sample_if.sv]
`default_nettype none

interface jsas_sample_if import jsas_pkg::*; ();

    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);

endinterface

`default_nettype wire

[design/jsas_result_if.sv]
`default_nettype none

interface jsas_result_if import jsas_pkg::*; ();

    logic                         valid;
    logic                         ready;
    logic signed [VALUE_BITS-1:0] x_position;
    logic signed [VALUE_BITS-1:0] y_position;
    logic signed [VALUE_BITS-1:0] left_position;
    logic signed [VALUE_BITS-1:0] right_position;
    logic [2:0]                   direction;
    logic [1:0]                   next_channel;

    modport source (
        output valid, output x_position, output y_position, output left_position,
        output right_position, output direction, output next_channel, input ready
    );
    modport sink (
        input valid, input x_position, input y_position, input left_position,
        input right_position, input direction, input next_channel, output ready
    );

endinterface

`default_nettype wire

[design/jsas_cfg_if.sv]
`default_nettype none

interface jsas_cfg_if import jsas_pkg::*; ();

    logic                      valid;
    logic                      ready;
    logic [CFG_INDEX_BITS-1:0] index;
    logic [CFG_DATA_BITS-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);

endinterface

`default_nettype wire

[design/jsas_cfg_regs.sv]
`default_nettype none

module jsas_cfg_regs import jsas_pkg::*; (
    input  wire logic clk,
    input  wire logic rst_n,
    jsas_cfg_if.sink  cfg,
    output cfg_t      regs
);

    cfg_t regs_reg;
    cfg_t regs_next;

    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    always_comb
    begin
        regs_next = regs_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                REG_X_OFFSET:    regs_next.x_offset_level = cfg.data[OFFSET_BITS-1:0];
                REG_Y_OFFSET:    regs_next.y_offset_level = cfg.data[OFFSET_BITS-1:0];
                REG_X_SPAN:      regs_next.x_span         = cfg.data[SPAN_BITS-1:0];
                REG_Y_SPAN:      regs_next.y_span         = cfg.data[SPAN_BITS-1:0];
                REG_LEFT_SPAN:   regs_next.left_span      = cfg.data[SPAN_BITS-1:0];
                REG_RIGHT_SPAN:  regs_next.right_span     = cfg.data[SPAN_BITS-1:0];
                REG_X_DEAD_ZONE: regs_next.x_dead_zone    = cfg.data[DZ_BITS-1:0];
                REG_Y_DEAD_ZONE: regs_next.y_dead_zone    = cfg.data[DZ_BITS-1:0];
                default:         regs_next = regs_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.x_offset_level <= '0;
            regs_reg.y_offset_level <= '0;
            regs_reg.x_span         <= SPAN_BITS'(255);
            regs_reg.y_span         <= SPAN_BITS'(255);
            regs_reg.left_span      <= SPAN_BITS'(255);
            regs_reg.right_span     <= SPAN_BITS'(255);
            regs_reg.x_dead_zone    <= DZ_BITS'(10);
            regs_reg.y_dead_zone    <= DZ_BITS'(65);
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

endmodule

`default_nettype wire

[design/jsas_divider.sv]
`default_nettype none

// Restoring divider: one quotient bit per cycle. The dividend shifts out of
// the top of the quotient register while quotient bits shift in at the bottom.
module jsas_divider import jsas_pkg::*; (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic [PROD_BITS-1:0] dividend,
    input  wire logic [SPAN_BITS-1:0] divisor,
    output logic [PROD_BITS-1:0]      quotient,
    output logic                      done
);

    localparam int CNT_BITS = $clog2(PROD_BITS);
    localparam logic [CNT_BITS-1:0] LAST_STEP = CNT_BITS'(PROD_BITS - 1);

    logic                 busy_reg,  busy_next;
    logic                 done_reg,  done_next;
    logic [CNT_BITS-1:0]  count_reg, count_next;
    logic [SPAN_BITS-1:0] rem_reg,   rem_next;
    logic [SPAN_BITS-1:0] dvs_reg,   dvs_next;
    logic [PROD_BITS-1:0] quo_reg,   quo_next;

    logic [SPAN_BITS:0]   partial;
    logic [SPAN_BITS:0]   diff;
    logic                 fits;

    assign partial  = {rem_reg, quo_reg[PROD_BITS-1]};
    assign diff     = partial - {1'b0, dvs_reg};
    assign fits     = partial >= {1'b0, dvs_reg};
    assign quotient = quo_reg;
    assign done     = done_reg;

    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        count_next = count_reg;
        rem_next   = rem_reg;
        dvs_next   = dvs_reg;
        quo_next   = quo_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            count_next = '0;
            rem_next   = '0;
            dvs_next   = divisor;
            quo_next   = dividend;
        end
        else if (busy_reg)
        begin
            // The remainder stays below the divisor, so the difference fits.
            rem_next   = fits ? diff[SPAN_BITS-1:0] : partial[SPAN_BITS-1:0];
            quo_next   = {quo_reg[PROD_BITS-2:0], fits};
            count_next = count_reg + 1'b1;
            if (count_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        quo_reg <= quo_next;
    end

endmodule

`default_nettype wire

[design/jsas_direction.sv]
`default_nettype none

module jsas_direction import jsas_pkg::*; (
    input  wire value_t             x_value,
    input  wire value_t             y_value,
    input  wire logic [DZ_BITS-1:0] x_dead_zone,
    input  wire logic [DZ_BITS-1:0] y_dead_zone,
    output direction_t              direction
);

    // One extra bit so that the magnitude of the most negative value fits.
    logic signed [VALUE_BITS:0] x_wide, y_wide;
    logic [VALUE_BITS:0]        ax, ay;

    assign x_wide = {x_value[VALUE_BITS-1], x_value};
    assign y_wide = {y_value[VALUE_BITS-1], y_value};
    assign ax     = x_value[VALUE_BITS-1] ? -x_wide : x_wide;
    assign ay     = y_value[VALUE_BITS-1] ? -y_wide : y_wide;

    always_comb
    begin
        if (ax >= ay)
        begin
            if (ax < (VALUE_BITS + 1)'(x_dead_zone))
                direction = DIR_NEUTRAL;
            else
                direction = x_value[VALUE_BITS-1] ? DIR_LEFT : DIR_RIGHT;
        end
        else
        begin
            if (ay < (VALUE_BITS + 1)'(y_dead_zone))
                direction = DIR_NEUTRAL;
            else
                direction = y_value[VALUE_BITS-1] ? DIR_DOWN : DIR_UP;
        end
    end

endmodule

`default_nettype wire

[design/joystick_slider_adc_scanner.sv]
// Channel   Role           Carries
// samples   input stream   sample: ADC reading for the channel given by next_channel
// results   output stream  four scaled positions, direction, next_channel
// cfg       write port     index and data of one configuration register
//
// After a sample's transfer the divider is loaded, works out sixteen quotient bits
// one at a time, the position is stored and the result register is loaded once it
// is free; no new sample is taken until the sequencer is back in its idle state.
// Reset clears the phase to joystick X, the stored positions to zero and the
// registers to their defaults. A result waiting at the output does not stop the
// next sample being taken; only the finished next result waits for it.
`default_nettype none

module joystick_slider_adc_scanner import jsas_pkg::*; (
    input  wire logic     clk,
    input  wire logic     rst_n,
    jsas_sample_if.sink   samples,
    jsas_result_if.source results,
    jsas_cfg_if.sink      cfg
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_DIV,
        S_REPORT
    } state_t;

    state_t                 state_reg,  state_next;
    scan_chan_t             phase_reg,  phase_next;
    logic [SAMPLE_BITS-1:0] mag_reg,    mag_next;
    logic                   neg_reg,    neg_next;
    value_t                 x_reg,      x_next;
    value_t                 y_reg,      y_next;
    value_t                 left_reg,   left_next;
    value_t                 right_reg,  right_next;
    logic                   ovalid_reg, ovalid_next;
    value_t                 ox_reg,     ox_next;
    value_t                 oy_reg,     oy_next;
    value_t                 oleft_reg,  oleft_next;
    value_t                 oright_reg, oright_next;
    direction_t             odir_reg,   odir_next;
    scan_chan_t             ochan_reg,  ochan_next;

    cfg_t                       regs;
    logic                       div_start;
    logic [PROD_BITS-1:0]       product;
    logic [SPAN_BITS-1:0]       span_sel;
    logic [SPAN_BITS-1:0]       divisor;
    logic [PROD_BITS-1:0]       quotient;
    logic                       div_done;
    direction_t                 dir_now;

    logic signed [SAMPLE_BITS:0] diff;
    logic [OFFSET_BITS-1:0]      offset_sel;
    logic signed [RES_BITS-1:0]  q_wide;
    logic signed [RES_BITS-1:0]  scaled;
    value_t                      scaled_sat;

    jsas_cfg_regs u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    jsas_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (product),
        .divisor  (divisor),
        .quotient (quotient),
        .done     (div_done)
    );

    jsas_direction u_dir (
        .x_value     (x_reg),
        .y_value     (y_reg),
        .x_dead_zone (regs.x_dead_zone),
        .y_dead_zone (regs.y_dead_zone),
        .direction   (dir_now)
    );

    assign samples.ready          = (state_reg == S_IDLE);
    assign results.valid          = ovalid_reg;
    assign results.x_position     = ox_reg;
    assign results.y_position     = oy_reg;
    assign results.left_position  = oleft_reg;
    assign results.right_position = oright_reg;
    assign results.direction      = odir_reg;
    assign results.next_channel   = ochan_reg;

    always_comb
    begin
        case (phase_reg)
            CH_X:    span_sel = regs.x_span;
            CH_Y:    span_sel = regs.y_span;
            CH_LEFT: span_sel = regs.left_span;
            default: span_sel = regs.right_span;
        endcase
    end

    // A span of zero divides as one.
    assign divisor    = (span_sel == '0) ? SPAN_BITS'(1) : span_sel;
    assign offset_sel = (phase_reg == CH_X) ? regs.x_offset_level : regs.y_offset_level;
    assign diff       = $signed({1'b0, samples.sample})
                        - $signed((SAMPLE_BITS + 1)'(offset_sel));
    assign product    = PROD_BITS'(mag_reg) * PROD_BITS'(FULL_SCALE_C);
    assign div_start  = (state_reg == S_MUL);

    // Quotient of the magnitude; the sign is put back so that it truncates
    // toward zero. Sliders are shifted down by half the full scale.
    assign q_wide = $signed({2'b00, quotient});
    always_comb
    begin
        if (phase_reg == CH_LEFT || phase_reg == CH_RIGHT)
            scaled = q_wide - $signed(HALF_SCALE_C);
        else if (neg_reg)
            scaled = -q_wide;
        else
            scaled = q_wide;
        if (scaled > VAL_MAX)
            scaled_sat = VALUE_BITS'(VAL_MAX);
        else if (scaled < VAL_MIN)
            scaled_sat = VALUE_BITS'(VAL_MIN);
        else
            scaled_sat = scaled[VALUE_BITS-1:0];
    end

    always_comb
    begin
        state_next  = state_reg;
        phase_next  = phase_reg;
        mag_next    = mag_reg;
        neg_next    = neg_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        left_next   = left_reg;
        right_next  = right_reg;
        ovalid_next = ovalid_reg;
        ox_next     = ox_reg;
        oy_next     = oy_reg;
        oleft_next  = oleft_reg;
        oright_next = oright_reg;
        odir_next   = odir_reg;
        ochan_next  = ochan_reg;

        if (results.valid && results.ready)
            ovalid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (samples.valid)
                begin
                    if (phase_reg == CH_X || phase_reg == CH_Y)
                    begin
                        neg_next = diff[SAMPLE_BITS];
                        mag_next = diff[SAMPLE_BITS] ? SAMPLE_BITS'(-diff)
                                                     : diff[SAMPLE_BITS-1:0];
                    end
                    else
                    begin
                        neg_next = 1'b0;
                        mag_next = samples.sample;
                    end
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    case (phase_reg)
                        CH_X:    x_next     = scaled_sat;
                        CH_Y:    y_next     = scaled_sat;
                        CH_LEFT: left_next  = scaled_sat;
                        default: right_next = scaled_sat;
                    endcase
                    phase_next = scan_chan_t'(phase_reg + 2'd1);
                    state_next = S_REPORT;
                end
            end
            S_REPORT:
            begin
                if (!results.valid || results.ready)
                begin
                    ovalid_next = 1'b1;
                    ox_next     = x_reg;
                    oy_next     = y_reg;
                    oleft_next  = left_reg;
                    oright_next = right_reg;
                    odir_next   = dir_now;
                    ochan_next  = phase_reg;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            phase_reg  <= CH_X;
            mag_reg    <= '0;
            neg_reg    <= 1'b0;
            x_reg      <= '0;
            y_reg      <= '0;
            left_reg   <= '0;
            right_reg  <= '0;
            ovalid_reg <= 1'b0;
            ox_reg     <= '0;
            oy_reg     <= '0;
            oleft_reg  <= '0;
            oright_reg <= '0;
            odir_reg   <= DIR_NEUTRAL;
            ochan_reg  <= CH_X;
        end
        else
        begin
            state_reg  <= state_next;
            phase_reg  <= phase_next;
            mag_reg    <= mag_next;
            neg_reg    <= neg_next;
            x_reg      <= x_next;
            y_reg      <= y_next;
            left_reg   <= left_next;
            right_reg  <= right_next;
            ovalid_reg <= ovalid_next;
            ox_reg     <= ox_next;
            oy_reg     <= oy_next;
            oleft_reg  <= oleft_next;
            oright_reg <= oright_next;
            odir_reg   <= odir_next;
            ochan_reg  <= ochan_next;
        end
    end

    // After a sample transfer the block is busy for the following cycle.
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        samples.valid && samples.ready |=> !samples.ready)
        else $error("sample taken while a conversion was starting");

    // The divider only finishes while the sequencer waits for it.
    a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == S_DIV)
        else $error("divider finished outside the divide state");

    // A pending result while idle names the channel the phase points at.
    a_chan_matches: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && state_reg == S_IDLE |-> results.next_channel == phase_reg)
        else $error("reported next channel differs from the phase");

    // A result is offered exactly as the sequencer leaves the report state.
    a_report_loads: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_REPORT && state_next == S_IDLE |=> results.valid)
        else $error("report state left without offering a result");

endmodule

`default_nettype wire
